FILE: hw/rtl/ctc_pkg.sv
// shared types and codes for the connection table
`default_nettype none
package ctc_pkg;

   localparam int unsigned KEY_W  = 32;
   localparam int unsigned ADDR_W = 32;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_FIND   = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // one table entry
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [ADDR_W-1:0] in_addr;
      logic [ADDR_W-1:0] out_addr;
   } slot_type;

   // token handed down the chain while searching for the newest match
   typedef struct packed {
      logic              seen;
      logic [ADDR_W-1:0] in_addr;
      logic [ADDR_W-1:0] out_addr;
   } sweep_type;

   // commands broadcast from the controller to every cell
   typedef struct packed {
      logic sweep_clear;
      logic sweep_step;
      logic push;
      logic clear;
      logic remove;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: hw/rtl/ctc_cell.sv
// one table slot with its compare and its stage of the search chain
`default_nettype none
module ctc_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctc_pkg::cell_ctl_type     ctl,
   input  wire logic [ctc_pkg::KEY_W-1:0] key,
   input  wire ctc_pkg::slot_type         prev_slot,
   input  wire ctc_pkg::slot_type         next_slot,
   input  wire ctc_pkg::sweep_type        sweep_prev,
   output ctc_pkg::slot_type              slot,
   output ctc_pkg::sweep_type             sweep
);
   import ctc_pkg::*;

   slot_type  slot_ff, slot_in;
   sweep_type sweep_ff, sweep_in;
   logic      match;

   assign match = slot_ff.valid && (slot_ff.key == key);

   always_comb begin
      slot_in = slot_ff;
      if (ctl.clear) begin
         slot_in.valid = 1'b0;
      end else if (ctl.push) begin
         slot_in = prev_slot;
      end else if (ctl.remove && sweep_ff.seen) begin
         // this slot is at or behind the deleted one: close the gap
         slot_in = next_slot;
      end
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (ctl.sweep_clear) begin
         sweep_in.seen = 1'b0;
      end else if (ctl.sweep_step) begin
         sweep_in.seen = sweep_prev.seen || match;
         if (sweep_prev.seen) begin
            sweep_in.in_addr  = sweep_prev.in_addr;
            sweep_in.out_addr = sweep_prev.out_addr;
         end else begin
            sweep_in.in_addr  = slot_ff.in_addr;
            sweep_in.out_addr = slot_ff.out_addr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
         sweep_ff.seen <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
         sweep_ff.seen <= sweep_in.seen;
      end
      slot_ff.key       <= slot_in.key;
      slot_ff.in_addr   <= slot_in.in_addr;
      slot_ff.out_addr  <= slot_in.out_addr;
      sweep_ff.in_addr  <= sweep_in.in_addr;
      sweep_ff.out_addr <= sweep_in.out_addr;
   end

   assign slot  = slot_ff;
   assign sweep = sweep_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/connection_table_cam_core.sv
// connection table top level: controller, result register and chain of slots
`default_nettype none
// channel  dir  tuser                 tdata
// req_     in   [1:0] opcode          [31:0] conn_id, [63:32] new_in_addr,
//                                     [95:64] new_out_addr
// rsp_     out  [1:0] status          [31:0] found_in_addr, [63:32] found_out_addr
//
// one word is taken at a time; push and clear go from accept straight to the result,
// while find and delete first sweep the search token, rippling one slot
// per cycle down the chain of cells.
// reset empties the table at once; entries need no clearing pass.
// a result waiting on rsp_tready holds the table commit of the following word.
module connection_table_cam_core #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // opcode
   input  wire logic [95:0] req_tdata,   // conn_id, new_in_addr, new_out_addr
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,   // status
   output logic [63:0]      rsp_tdata    // found_in_addr, found_out_addr
);
   import ctc_pkg::*;

   localparam int unsigned CNT_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  cnt_ff;
   opcode_type        op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [ADDR_W-1:0] new_in_ff;
   logic [ADDR_W-1:0] new_out_ff;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [ADDR_W-1:0] rsp_in_ff;
   logic [ADDR_W-1:0] rsp_out_ff;

   logic              accept;
   logic              rsp_free;
   logic              commit;
   logic              full;
   logic              hit;
   cell_ctl_type      ctl;
   status_type        status_in;
   logic [ADDR_W-1:0] fin_in;
   logic [ADDR_W-1:0] fout_in;

   slot_type  slots  [TABLE_DEPTH];
   slot_type  prevs  [TABLE_DEPTH];
   slot_type  nexts  [TABLE_DEPTH];
   sweep_type sweeps [TABLE_DEPTH];
   sweep_type sprevs [TABLE_DEPTH];

   assign accept   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign commit   = (state_ff == S_DONE) && rsp_free;
   assign full     = slots[TABLE_DEPTH-1].valid;
   assign hit      = sweeps[TABLE_DEPTH-1].seen;

   always_comb begin
      ctl.sweep_clear = accept;
      ctl.sweep_step  = (state_ff == S_SWEEP);
      ctl.push        = commit && (op_ff == OP_PUSH) && !full;
      ctl.clear       = commit && (op_ff == OP_CLEAR);
      ctl.remove      = commit && (op_ff == OP_DELETE) && hit;
   end

   always_comb begin
      status_in = ST_OK;
      fin_in    = '0;
      fout_in   = '0;
      case (op_ff)
         OP_PUSH: begin
            if (full) status_in = ST_FULL;
         end
         OP_FIND: begin
            if (hit) begin
               fin_in  = sweeps[TABLE_DEPTH-1].in_addr;
               fout_in = sweeps[TABLE_DEPTH-1].out_addr;
            end else begin
               status_in = ST_MISS;
            end
         end
         OP_DELETE: begin
            if (!hit) status_in = ST_MISS;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= commit || (rsp_valid_ff && !rsp_tready);
         if (commit) begin
            rsp_status_ff <= status_in;
            rsp_in_ff     <= fin_in;
            rsp_out_ff    <= fout_in;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cnt_ff <= '0;
                  if (opcode_type'(req_tuser) == OP_FIND ||
                      opcode_type'(req_tuser) == OP_DELETE) begin
                     state_ff <= S_SWEEP;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_SWEEP: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(TABLE_DEPTH - 1)) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (rsp_free) state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= opcode_type'(req_tuser);
         key_ff     <= req_tdata[31:0];
         new_in_ff  <= req_tdata[63:32];
         new_out_ff <= req_tdata[95:64];
      end
   end

   genvar i;
   generate
      for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         if (i == 0) begin : g_head
            assign prevs[i]  = '{valid: 1'b1, key: key_ff, in_addr: new_in_ff,
                                 out_addr: new_out_ff};
            assign sprevs[i] = '{seen: 1'b0, in_addr: '0, out_addr: '0};
         end else begin : g_body
            assign prevs[i]  = slots[i-1];
            assign sprevs[i] = sweeps[i-1];
         end
         if (i == TABLE_DEPTH - 1) begin : g_tail
            assign nexts[i] = '{valid: 1'b0, key: '0, in_addr: '0, out_addr: '0};
         end else begin : g_mid
            assign nexts[i] = slots[i+1];
         end
         ctc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .key        (key_ff),
            .prev_slot  (prevs[i]),
            .next_slot  (nexts[i]),
            .sweep_prev (sprevs[i]),
            .slot       (slots[i]),
            .sweep      (sweeps[i])
         );
      end
   endgenerate

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_out_ff, rsp_in_ff};

endmodule
`default_nettype wire
